/* design/elevator_passenger_scheduler_assert.svh */
// Assertion macros for the elevator passenger scheduler
`ifndef ELEVATOR_PASSENGER_SCHEDULER_ASSERT_SVH
`define ELEVATOR_PASSENGER_SCHEDULER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define EPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/eps_pkg.sv */
// Shared types and constants of the elevator passenger scheduler
`default_nettype none
package eps_pkg;
  localparam int unsigned MaxPass = 16;
  localparam int unsigned IdxW    = $clog2(MaxPass);
  localparam int unsigned CntW    = $clog2(MaxPass + 1);

  typedef enum logic [2:0] {
    KIND_STATUS  = 3'd0,
    KIND_LEFT    = 3'd1,
    KIND_BOARDED = 3'd2,
    KIND_ADD_OK  = 3'd3,
    KIND_ADD_REJ = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_ROT   = 2'd2,
    CELL_SHIFT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [3:0] start_floor;
    logic [3:0] target_floor;
    logic [7:0] weight;
    logic [7:0] tag;
    logic       riding;
  } entry_t;

  typedef struct packed {
    cell_op_e        op;
    logic [IdxW-1:0] pos;
    entry_t          wr;
  } cell_ctl_t;
endpackage
`default_nettype wire

/* design/eps_cell.sv */
// One passenger slot of the table chain
`default_nettype none
module eps_cell (
  input  logic                  clk_i,
  input  logic [eps_pkg::IdxW-1:0] idx_i,
  input  eps_pkg::cell_ctl_t    ctl_i,
  input  eps_pkg::entry_t       nb_i,
  output eps_pkg::entry_t       entry_o
);
  import eps_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      CELL_LOAD: begin
        if (idx_i == ctl_i.pos) entry_d = ctl_i.wr;
      end
      CELL_ROT: begin
        entry_d = (idx_i == ctl_i.pos) ? ctl_i.wr : nb_i;
      end
      CELL_SHIFT: entry_d = nb_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

/* design/elevator_passenger_scheduler.sv */
// Top level of the elevator passenger scheduler
//
//  channel  direction  handshake               payload
//  in       sink       in_valid_i / in_ready_o  op, floors, weight, tag
//  out      source     out_valid_o / out_ready_i kind, tag, car state, last
//  cfg      APB        psel .. pready           load_capacity, top_floor
//
// An add gives one result.
// In a tick the table chain rotates once past its head for leaving riders and once
// more for boarding. Reset clears counts and load and presets floor, direction and
// config; payload registers and table slots are not reset but written before use.
// A waiting result stalls the sequencer until it is taken.
`default_nettype none
module elevator_passenger_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [3:0]  start_floor_i,
  input  logic [3:0]  target_floor_i,
  input  logic [7:0]  passenger_weight_i,
  input  logic [7:0]  passenger_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  event_tag_o,
  output logic [3:0]  car_floor_o,
  output logic        going_up_o,
  output logic [10:0] car_load_o,
  output logic [4:0]  rider_count_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import eps_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_UNLOAD = 2'd1;
  localparam logic [1:0] ST_BOARD  = 2'd2;

  logic [1:0]      st_q, st_d;
  logic [10:0]     cap_q, cap_d;
  logic [3:0]      top_q, top_d;
  logic [CntW-1:0] total_q, total_d, cnt_q, cnt_d;
  logic [3:0]      floor_q, floor_d;
  logic            up_q, up_d;
  logic [10:0]     load_q, load_d;
  logic [4:0]      riders_q, riders_d;

  logic            ov_q, ov_d;
  logic [2:0]      kind_q, kind_d;
  logic [7:0]      tag_q, tag_d;
  logic [3:0]      ofl_q, ofl_d;
  logic            oup_q, oup_d;
  logic [10:0]     old_q, old_d;
  logic [4:0]      orid_q, orid_d;
  logic            olast_q, olast_d;

  cell_ctl_t ctl;
  entry_t    cells [MaxPass];
  entry_t    head;

  logic        adv, emit, in_acc, add_ok;
  logic [3:0]  top_eff;
  logic [11:0] board_sum;
  logic [CntW-1:0] tail;

  for (genvar g = 0; g < MaxPass; g++) begin : g_cell
    entry_t nb;
    if (g == MaxPass - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cells[g+1];
    end
    eps_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(g)),
      .ctl_i   (ctl),
      .nb_i    (nb),
      .entry_o (cells[g])
    );
  end

  assign head      = cells[0];
  assign top_eff   = (top_q < 4'd2) ? 4'd2 : top_q;
  assign adv       = !ov_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE) && adv;
  assign in_acc    = in_valid_i && in_ready_o;
  assign board_sum = {1'b0, load_q} + {4'd0, head.weight};
  assign tail      = total_q - CntW'(1);
  assign add_ok    = (total_q != CntW'(MaxPass)) && (start_floor_i != 4'd0) &&
                     (start_floor_i <= top_eff) && (target_floor_i != 4'd0) &&
                     (target_floor_i <= top_eff) && (start_floor_i != target_floor_i);

  always_comb begin
    st_d = st_q; cap_d = cap_q; top_d = top_q; total_d = total_q; cnt_d = cnt_q;
    floor_d = floor_q; up_d = up_q; load_d = load_q; riders_d = riders_q;
    ov_d = ov_q && !out_ready_i;
    kind_d = kind_q; tag_d = tag_q; ofl_d = ofl_q; oup_d = oup_q;
    old_d = old_q; orid_d = orid_q; olast_d = olast_q;
    emit = 1'b0;
    ctl.op  = CELL_HOLD;
    ctl.pos = tail[IdxW-1:0];
    ctl.wr  = head;

    if (psel && penable && pwrite) begin
      if (paddr[2]) top_d = pwdata[3:0];
      else cap_d = pwdata[10:0];
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!op_i) begin
            emit    = 1'b1;
            kind_d  = add_ok ? KIND_ADD_OK : KIND_ADD_REJ;
            tag_d   = passenger_tag_i;
            olast_d = 1'b1;
            if (add_ok) begin
              ctl.op  = CELL_LOAD;
              ctl.pos = total_q[IdxW-1:0];
              ctl.wr  = '{start_floor_i, target_floor_i, passenger_weight_i,
                          passenger_tag_i, 1'b0};
              total_d = total_q + CntW'(1);
            end
          end else begin
            if (floor_q >= top_eff) up_d = 1'b0;
            else if (floor_q <= 4'd1) up_d = 1'b1;
            else up_d = up_q;
            floor_d = up_d ? floor_q + 4'd1 : floor_q - 4'd1;
            cnt_d   = total_q;
            st_d    = ST_UNLOAD;
          end
        end
      end
      ST_UNLOAD: begin
        if (adv) begin
          if (cnt_q == '0) begin
            cnt_d = total_q;
            st_d  = ST_BOARD;
          end else begin
            cnt_d = cnt_q - CntW'(1);
            if (head.riding && head.target_floor == floor_q) begin
              ctl.op   = CELL_SHIFT;
              total_d  = tail;
              load_d   = (load_q >= {3'd0, head.weight}) ? load_q - {3'd0, head.weight}
                                                         : 11'd0;
              riders_d = (riders_q != 5'd0) ? riders_q - 5'd1 : 5'd0;
              emit     = 1'b1;
              kind_d   = KIND_LEFT;
              tag_d    = head.tag;
              olast_d  = 1'b0;
            end else begin
              ctl.op = CELL_ROT;
            end
          end
        end
      end
      ST_BOARD: begin
        if (adv) begin
          if (cnt_q == '0) begin
            st_d    = ST_IDLE;
            emit    = 1'b1;
            kind_d  = KIND_STATUS;
            tag_d   = 8'd0;
            olast_d = 1'b1;
          end else begin
            cnt_d  = cnt_q - CntW'(1);
            ctl.op = CELL_ROT;
            if (!head.riding && head.start_floor == floor_q &&
                board_sum <= {1'b0, cap_q}) begin
              ctl.wr.riding = 1'b1;
              load_d   = board_sum[10:0];
              riders_d = riders_q + 5'd1;
              emit     = 1'b1;
              kind_d   = KIND_BOARDED;
              tag_d    = head.tag;
              olast_d  = 1'b0;
            end
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (emit) begin
      ov_d   = 1'b1;
      ofl_d  = floor_d;
      oup_d  = up_d;
      old_d  = load_d;
      orid_d = riders_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cap_q    <= 11'd1000;
      top_q    <= 4'd7;
      total_q  <= '0;
      cnt_q    <= '0;
      floor_q  <= 4'd7;
      up_q     <= 1'b1;
      load_q   <= '0;
      riders_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      cap_q    <= cap_d;
      top_q    <= top_d;
      total_q  <= total_d;
      cnt_q    <= cnt_d;
      floor_q  <= floor_d;
      up_q     <= up_d;
      load_q   <= load_d;
      riders_q <= riders_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    tag_q   <= tag_d;
    ofl_q   <= ofl_d;
    oup_q   <= oup_d;
    old_q   <= old_d;
    orid_q  <= orid_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign kind_o        = kind_q;
  assign event_tag_o   = tag_q;
  assign car_floor_o   = ofl_q;
  assign going_up_o    = oup_q;
  assign car_load_o    = old_q;
  assign rider_count_o = orid_q;
  assign last_o        = olast_q;
  assign pready        = 1'b1;
  assign prdata        = paddr[2] ? {28'd0, top_q} : {21'd0, cap_q};
endmodule
`default_nettype wire

/* design/eps_checker.sv */
// Port checker of the elevator passenger scheduler and its bind
`default_nettype none
`include "elevator_passenger_scheduler_assert.svh"
module eps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  event_tag_o,
  input logic [4:0]  rider_count_o,
  input logic        last_o
);
  import eps_pkg::*;

  `EPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o))
  `EPS_ASSERT_SAME(a_status_last, out_valid_o && kind_o == KIND_STATUS, last_o && event_tag_o == 8'd0)
  `EPS_ASSERT_SAME(a_add_last, out_valid_o && (kind_o == KIND_ADD_OK || kind_o == KIND_ADD_REJ), last_o)
  `EPS_ASSERT_SAME(a_riders_max, out_valid_o, rider_count_o <= 5'(MaxPass))
endmodule

bind elevator_passenger_scheduler eps_checker u_eps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .event_tag_o   (event_tag_o),
  .rider_count_o (rider_count_o),
  .last_o        (last_o)
);
`default_nettype wire
